@@ design/smft_pkg.sv @@
// ----------------------------------------------------------------------------
// smft_pkg: seen message flag table shared definitions
// Opcodes, flag selectors, table word layout, sequencer states and the
// result type of the compare unit.
// ----------------------------------------------------------------------------
package smft_pkg;

    localparam int ID_W    = 16;
    localparam int FLAG_W  = 3;
    localparam int WORD_W  = ID_W + FLAG_W;   // {flags, id}
    localparam int SEL_W   = 2;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 8;

    localparam logic OP_TEST_SET = 1'b0;
    localparam logic OP_CLEAR    = 1'b1;

    localparam logic [SEL_W-1:0] SEL_FLOOD   = 2'd0;
    localparam logic [SEL_W-1:0] SEL_INVERSE = 2'd1;
    localparam logic [SEL_W-1:0] SEL_UNICAST = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HIT,
        ST_MISS,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              hit;
        logic              old_set;
        logic [FLAG_W-1:0] new_flags;
    } t_match;

    // One-hot flag for a selector; the unused code selects nothing.
    function automatic logic [FLAG_W-1:0] flag_mask(input logic [SEL_W-1:0] sel);
        logic [FLAG_W-1:0] m;
        unique case (sel)
            SEL_FLOOD:   m = 3'b001;
            SEL_INVERSE: m = 3'b010;
            SEL_UNICAST: m = 3'b100;
            default:     m = 3'b000;
        endcase
        return m;
    endfunction

endpackage

@@ design/seen_message_flag_table_core.sv @@
// ----------------------------------------------------------------------------
// seen_message_flag_table_core: duplicate message suppression table
// Flow: an accepted item is scanned linearly through the table RAM, one entry
//   read per cycle and compared once its data is back, until a hit or the last
//   valid entry; a hit then rewrites its entry, a miss inserts a new one, and a
//   miss on an empty table skips the scan. A clear empties the table directly.
//   The result waits in ST_DONE under back-pressure; a new item is taken only in ST_IDLE.
// Reset: fill count, write pointer and output register are cleared; the RAM
//   is not swept, entries at or above the fill count are never read.
// ----------------------------------------------------------------------------
module seen_message_flag_table_core #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [15:0] message_id, [17:16] flag_select
    input  logic        i_s_tuser,   // [0] opcode
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata    // [0] was_known, [1] was_set
);
    import smft_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [AW-1:0] LAST_A  = AW'(TABLE_DEPTH - 1);

    // Control registers
    t_state        r_state, n_state;
    logic [CW-1:0] r_fill, n_fill;        // valid entries, saturates at depth
    logic [AW-1:0] r_wp, n_wp;            // next entry to overwrite
    logic [AW-1:0] r_addr, n_addr;        // next scan read address
    logic          r_issued, n_issued;    // all scan reads issued
    logic          r_pend, n_pend;        // RAM data from last read is valid
    logic          r_out_valid, n_out_valid;

    // Payload registers
    logic [ID_W-1:0]   r_id, n_id;
    logic [SEL_W-1:0]  r_sel, n_sel;
    logic [AW-1:0]     r_paddr, n_paddr;  // address of pending read data
    logic              r_plast, n_plast;  // pending read is the last entry
    logic [AW-1:0]     r_hit_addr, n_hit_addr;
    logic [FLAG_W-1:0] r_flags, n_flags;  // updated flags of the hit entry
    logic              r_known, n_known;
    logic              r_set, n_set;
    logic              r_out_known, n_out_known;
    logic              r_out_set, n_out_set;

    // RAM and compare unit
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;
    t_match            match;
    logic              s_acc;

    smft_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    smft_match u_match (
        .i_word (ram_rdata),
        .i_id   (r_id),
        .i_sel  (r_sel),
        .o_res  (match)
    );

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out_set, r_out_known};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_wp        <= '0;
            r_addr      <= '0;
            r_issued    <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_wp        <= n_wp;
            r_addr      <= n_addr;
            r_issued    <= n_issued;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id        <= n_id;
        r_sel       <= n_sel;
        r_paddr     <= n_paddr;
        r_plast     <= n_plast;
        r_hit_addr  <= n_hit_addr;
        r_flags     <= n_flags;
        r_known     <= n_known;
        r_set       <= n_set;
        r_out_known <= n_out_known;
        r_out_set   <= n_out_set;
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_wp        = r_wp;
        n_addr      = r_addr;
        n_issued    = r_issued;
        n_pend      = 1'b0;
        n_out_valid = r_out_valid && !i_m_tready;
        n_id        = r_id;
        n_sel       = r_sel;
        n_paddr     = r_paddr;
        n_plast     = r_plast;
        n_hit_addr  = r_hit_addr;
        n_flags     = r_flags;
        n_known     = r_known;
        n_set       = r_set;
        n_out_known = r_out_known;
        n_out_set   = r_out_set;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = r_wp;
        ram_wdata   = {flag_mask(r_sel), r_id};

        unique case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    n_id     = i_s_tdata[15:0];
                    n_sel    = i_s_tdata[17:16];
                    n_addr   = '0;
                    n_issued = 1'b0;
                    if (i_s_tuser == OP_CLEAR) begin
                        // empty table: flags of stale entries are rewritten on insert
                        n_fill  = '0;
                        n_wp    = '0;
                        n_known = 1'b0;
                        n_set   = 1'b0;
                        n_state = ST_DONE;
                    end else if (r_fill == '0) begin
                        n_state = ST_MISS;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // read one entry per cycle; compare it the cycle after
                if (!r_issued) begin
                    ram_re  = 1'b1;
                    n_pend  = 1'b1;
                    n_paddr = r_addr;
                    n_plast = ((CW'(r_addr) + CW'(1)) == r_fill);
                    if ((CW'(r_addr) + CW'(1)) == r_fill) begin
                        n_issued = 1'b1;
                    end else begin
                        n_addr = r_addr + AW'(1);
                    end
                end
                if (r_pend) begin
                    if (match.hit) begin
                        n_pend     = 1'b0;
                        n_hit_addr = r_paddr;
                        n_set      = match.old_set;
                        n_flags    = match.new_flags;
                        n_state    = ST_HIT;
                    end else if (r_plast) begin
                        n_state = ST_MISS;
                    end
                end
            end
            ST_HIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_hit_addr;
                ram_wdata = {r_flags, r_id};
                n_known   = 1'b1;
                n_state   = ST_DONE;
            end
            ST_MISS: begin
                // new entry at the ring pointer, only the selected flag set
                ram_we  = 1'b1;
                n_wp    = (r_wp == LAST_A) ? '0 : r_wp + AW'(1);
                if (r_fill != DEPTH_C) begin
                    n_fill = r_fill + CW'(1);
                end
                n_known = 1'b0;
                n_set   = 1'b0;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_known = r_known;
                    n_out_set   = r_set;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Fill count never exceeds the table depth
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= DEPTH_C)
        else $error("fill count above table depth");

    // Until the table wraps, the write pointer tracks the fill count
    a_wp_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != DEPTH_C) |-> (CW'(r_wp) == r_fill))
        else $error("write pointer out of step with fill count");

    // Scan reads stay inside the valid entries
    a_scan_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && !r_issued) |-> (CW'(r_addr) < r_fill))
        else $error("scan read beyond valid entries");

    // A hit updates a valid entry
    a_hit_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HIT) |-> (CW'(r_hit_addr) < r_fill))
        else $error("hit write to invalid entry");

    // A clear transaction empties the table on the next cycle
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && i_s_tuser == OP_CLEAR) |=> (r_fill == '0 && r_wp == '0))
        else $error("clear did not empty table");

endmodule

@@ design/smft_ram.sv @@
// ----------------------------------------------------------------------------
// smft_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module smft_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/smft_match.sv @@
// ----------------------------------------------------------------------------
// smft_match: shared compare unit
// Compares one table word against the searched ID and forms the old flag
// value and the updated flag set.
// ----------------------------------------------------------------------------
module smft_match (
    input  logic [smft_pkg::WORD_W-1:0] i_word,
    input  logic [smft_pkg::ID_W-1:0]   i_id,
    input  logic [smft_pkg::SEL_W-1:0]  i_sel,
    output smft_pkg::t_match            o_res
);
    import smft_pkg::*;

    logic [FLAG_W-1:0] mask;
    logic [FLAG_W-1:0] flags;

    assign mask  = flag_mask(i_sel);
    assign flags = i_word[WORD_W-1:ID_W];

    always_comb begin
        o_res.hit       = (i_word[ID_W-1:0] == i_id);
        o_res.old_set   = |(flags & mask);
        o_res.new_flags = flags | mask;
    end

endmodule

@@ bench/seen_message_flag_table_core_tb.sv @@
// ----------------------------------------------------------------------------
// seen_message_flag_table_core_tb: duplicate message table testbench
// Drives test-and-set and clear transactions into the stream slave port,
// with random gaps and back-pressure on both sides. A local model of the
// ID/flag table predicts each result. Results are checked field by field
// in order of arrival.
// ----------------------------------------------------------------------------
module seen_message_flag_table_core_tb;

    import smft_pkg::*;

    localparam int DEPTH       = 128;
    localparam int CLK_HALF    = 5;
    localparam int RST_CYCLES  = 9;
    localparam int RAND_ITEMS  = 700;
    localparam int TAIL_CYCLES = DEPTH + 16;   // worst scan latency plus margin
    localparam int MAX_GAP     = 14;

    // selector code that maps to no flag
    localparam logic [SEL_W-1:0] SEL_NONE = 2'd3;

    typedef struct {
        logic             op;
        logic [ID_W-1:0]  id;
        logic [SEL_W-1:0] sel;
        bit               drain;   // hold until all pending results are back
    } t_table_req;

    typedef struct {
        logic known;
        logic was_set;
    } t_table_resp;

    // ------------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------------
    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [23:0] s_tdata  = '0;    // [15:0] message_id, [17:16] flag_select
    logic        s_tuser  = 1'b0;  // [0] opcode
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [7:0]  m_tdata;          // [0] was_known, [1] was_set

    seen_message_flag_table_core #(
        .TABLE_DEPTH (DEPTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------------
    t_table_req  req_q[$];          // transactions not yet put on the bus
    t_table_resp expected_resp_q[$];

    int unsigned req_issued   = 0;  // transactions presented by the driver
    int unsigned req_accepted = 0;  // slave handshakes seen by the monitor
    int unsigned resp_taken   = 0;  // master handshakes seen by the monitor
    int unsigned errors       = 0;
    bit          drv_busy     = 1'b0;

    // Local copy of the table. IDs at or above the fill count are never
    // looked at, so their contents do not matter.
    logic [ID_W-1:0]   id_tab   [DEPTH];
    logic [FLAG_W-1:0] flag_tab [DEPTH];
    int                fill_cnt = 0;
    int                wr_ptr   = 0;

    // ------------------------------------------------------------------------
    // Table model: search, test-and-set, insert on miss, or clear
    // ------------------------------------------------------------------------
    task automatic test_and_mark(input logic op, input logic [ID_W-1:0] id,
                                 input logic [SEL_W-1:0] sel);
        t_table_resp       r;
        logic [FLAG_W-1:0] mask;
        int                slot;
        r.known   = 1'b0;
        r.was_set = 1'b0;
        if (op == OP_CLEAR) begin
            foreach (flag_tab[k]) flag_tab[k] = '0;
            fill_cnt = 0;
            wr_ptr   = 0;
        end else begin
            mask = (sel == SEL_NONE) ? '0 : FLAG_W'(1) << sel;
            slot = -1;
            for (int k = 0; k < fill_cnt; k++)
                if (slot < 0 && id_tab[k] == id) slot = k;
            if (slot >= 0) begin
                r.known        = 1'b1;
                r.was_set      = |(flag_tab[slot] & mask);
                flag_tab[slot] = flag_tab[slot] | mask;
            end else begin
                // miss: overwrite oldest once full, fresh flags
                id_tab[wr_ptr]   = id;
                flag_tab[wr_ptr] = mask;
                wr_ptr = (wr_ptr + 1) % DEPTH;
                if (fill_cnt < DEPTH) fill_cnt++;
            end
        end
        expected_resp_q.push_back(r);
    endtask

    task automatic queue_req(input logic op, input logic [ID_W-1:0] id,
                             input logic [SEL_W-1:0] sel, input bit drain);
        t_table_req t;
        t.op    = op;
        t.id    = id;
        t.sel   = sel;
        t.drain = drain;
        req_q.push_back(t);
    endtask

    function automatic int draw_wait(input bit burst);
        return burst ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    // ------------------------------------------------------------------------
    // Driver: presents one transaction at a time at the falling edge. A
    // transaction counts as taken once the monitor has logged its handshake.
    // Stretches with no gaps come from the burst mode flipping now and then.
    // ------------------------------------------------------------------------
    int gap_left   = 0;
    bit send_burst = 1'b0;

    always @(negedge i_clk) begin
        bit         present;
        t_table_req nxt;
        if (i_rst_n) begin
            if (drv_busy && req_accepted == req_issued) drv_busy = 1'b0;
            present = drv_busy;
            if (!drv_busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (req_q.size() > 0 &&
                             (!req_q[0].drain || expected_resp_q.size() == 0)) begin
                    nxt = req_q.pop_front();
                    s_tdata    <= {6'b0, nxt.sel, nxt.id};
                    s_tuser    <= nxt.op;
                    req_issued++;
                    drv_busy = 1'b1;
                    present  = 1'b1;
                    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
                    gap_left = draw_wait(send_burst);
                end
            end
            s_tvalid <= present;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: after each result transaction, holds tready low for a drawn
    // number of cycles, whether or not a result is pending.
    // ------------------------------------------------------------------------
    int          stall_left = 0;
    int unsigned resp_seen  = 0;
    bit          recv_burst = 1'b0;

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (resp_seen != resp_taken) begin
                resp_seen = resp_taken;
                if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
                stall_left = draw_wait(recv_burst);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: at the rising edge, feeds accepted requests to the model and
    // checks each result transaction against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_table_resp exp_r;
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                test_and_mark(s_tuser, s_tdata[15:0], s_tdata[17:16]);
                req_accepted++;
            end
            if (m_tvalid && m_tready) begin
                resp_taken++;
                if (expected_resp_q.size() == 0) begin
                    $display("%0t: unexpected result, tdata %h", $time, m_tdata);
                    errors++;
                end else begin
                    exp_r = expected_resp_q.pop_front();
                    if (m_tdata[0] !== exp_r.known) begin
                        $display("%0t: was_known expected %0b actual %0b",
                                 $time, exp_r.known, m_tdata[0]);
                        errors++;
                    end
                    if (m_tdata[1] !== exp_r.was_set) begin
                        $display("%0t: was_set expected %0b actual %0b",
                                 $time, exp_r.was_set, m_tdata[1]);
                        errors++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    logic [ID_W-1:0] recent_ids[$];   // IDs inserted so far, newest last

    initial begin
        logic [ID_W-1:0] id;
        int              lo;

        // directed: clear on empty table, every flag on a hit and a miss,
        // unused selector, extreme IDs, clear with a loaded table
        queue_req(OP_CLEAR,    16'hFFFF, SEL_NONE,    1'b0);
        queue_req(OP_TEST_SET, 16'h0000, SEL_FLOOD,   1'b0);  // miss
        queue_req(OP_TEST_SET, 16'h0000, SEL_FLOOD,   1'b0);  // hit, already set
        queue_req(OP_TEST_SET, 16'h0000, SEL_INVERSE, 1'b0);
        queue_req(OP_TEST_SET, 16'h0000, SEL_UNICAST, 1'b0);
        queue_req(OP_TEST_SET, 16'h0000, SEL_UNICAST, 1'b0);
        queue_req(OP_TEST_SET, 16'h0000, SEL_NONE,    1'b0);
        queue_req(OP_TEST_SET, 16'hFFFF, SEL_NONE,    1'b0);  // miss, no flag set
        queue_req(OP_TEST_SET, 16'hFFFF, SEL_FLOOD,   1'b0);
        queue_req(OP_TEST_SET, 16'hFFFF, SEL_INVERSE, 1'b0);
        queue_req(OP_TEST_SET, 16'hAAAA, SEL_INVERSE, 1'b0);
        queue_req(OP_TEST_SET, 16'h5555, SEL_UNICAST, 1'b0);
        queue_req(OP_TEST_SET, 16'hAAAA, SEL_INVERSE, 1'b0);
        queue_req(OP_TEST_SET, 16'h5555, SEL_FLOOD,   1'b0);
        queue_req(OP_TEST_SET, 16'h5555, SEL_UNICAST, 1'b0);
        queue_req(OP_CLEAR,    16'h0000, SEL_FLOOD,   1'b0);
        queue_req(OP_TEST_SET, 16'h0000, SEL_FLOOD,   1'b0);  // miss after clear
        queue_req(OP_TEST_SET, 16'hFFFF, SEL_UNICAST, 1'b0);
        queue_req(OP_TEST_SET, 16'hFFFF, SEL_UNICAST, 1'b0);
        queue_req(OP_CLEAR,    16'h1234, SEL_UNICAST, 1'b1);  // after a full drain
        recent_ids = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555};

        // random: half repeats of recent IDs (hits, and misses once the
        // ring has evicted them), half fresh IDs that fill and wrap the table;
        // rare clears so the table runs full most of the time
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if ($urandom_range(0, 199) == 0) begin
                queue_req(OP_CLEAR, ID_W'($urandom), SEL_W'($urandom_range(0, 3)), 1'b0);
            end else begin
                if ($urandom_range(0, 1) == 1) begin
                    lo = (recent_ids.size() > 160) ? recent_ids.size() - 160 : 0;
                    id = recent_ids[$urandom_range(lo, recent_ids.size() - 1)];
                end else begin
                    id = ID_W'($urandom);
                    recent_ids.push_back(id);
                    if (recent_ids.size() > 256) void'(recent_ids.pop_front());
                end
                queue_req(OP_TEST_SET, id, SEL_W'($urandom_range(0, 3)),
                          $urandom_range(0, 99) == 0);
            end
        end

        // reset once, released at a falling edge
        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (req_q.size() > 0 || drv_busy || expected_resp_q.size() > 0)
            @(posedge i_clk);
        // catch anything spurious after the last expected result
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // watchdog: about eight times the slowest legal run
    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

@@ seen_message_flag_table_core.f @@
design/smft_pkg.sv
design/smft_ram.sv
design/smft_match.sv
design/seen_message_flag_table_core.sv
bench/seen_message_flag_table_core_tb.sv
